@@ rtl/ntt_pkg.sv @@
package ntt_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int MAX_RESULTS       = 16;
	localparam int RES_W             = $clog2(MAX_RESULTS + 1);

	localparam int MAC_W    = 48;
	localparam int WORD_W   = 32;
	localparam int RSSI_W   = 8;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;
	localparam int COUNT_W  = 5;

	localparam logic [WORD_W-1:0] STALE_RESET = 32'd30000;

	localparam logic OP_OBSERVE = 1'b0;
	localparam logic OP_REPORT  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NEW     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REPORT  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

	localparam logic [1:0] SEL_OBS   = 2'd0;
	localparam logic [1:0] SEL_FULL  = 2'd1;
	localparam logic [1:0] SEL_ENTRY = 2'd2;
	localparam logic [1:0] SEL_EMPTY = 2'd3;

	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic [WORD_W-1:0] seq;
		logic [WORD_W-1:0] seen;
		logic [RSSI_W-1:0] rssi;
		logic              rssi_ok;
		logic [WORD_W-1:0] hellos;
	} entry_t;

	typedef struct packed {
		logic       cap;
		logic       scan_en;
		logic       ptr_inc;
		logic       commit;
		logic       emit;
		logic [1:0] sel;
	} ctl_t;

	typedef struct packed {
		logic ptr_last;
		logic ptr_used;
		logic found;
		logic occ_zero;
		logic out_free;
		logic rpt_last;
	} sts_t;

endpackage

@@ rtl/ntt_ctrl.sv @@
module ntt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          opcode,
	output logic          in_stall,
	input  ntt_pkg::sts_t sts,
	output ntt_pkg::ctl_t ctl
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_SCAN_END = 3'd2;
	localparam logic [2:0] S_DECIDE   = 3'd3;
	localparam logic [2:0] S_EMIT_OBS = 3'd4;
	localparam logic [2:0] S_RPT      = 3'd5;
	localparam logic [2:0] S_RPT_EMIT = 3'd6;
	localparam logic [2:0] S_EMPTY    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.cap = 1'b1;
					state_d = (opcode == ntt_pkg::OP_REPORT) ? S_RPT : S_SCAN;
				end
			end
			S_SCAN: begin
				ctl.scan_en = 1'b1;
				if (sts.ptr_last) begin
					state_d = S_SCAN_END;
				end else begin
					ctl.ptr_inc = 1'b1;
				end
			end
			S_SCAN_END: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				ctl.commit = sts.found;
				state_d    = S_EMIT_OBS;
			end
			S_EMIT_OBS: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					ctl.sel  = sts.found ? ntt_pkg::SEL_OBS : ntt_pkg::SEL_FULL;
					state_d  = S_IDLE;
				end
			end
			S_RPT: begin
				if (sts.occ_zero) begin
					state_d = S_EMPTY;
				end else if (sts.ptr_used) begin
					state_d = S_RPT_EMIT;
				end else begin
					ctl.ptr_inc = 1'b1;
				end
			end
			S_RPT_EMIT: begin
				if (sts.out_free) begin
					ctl.emit    = 1'b1;
					ctl.sel     = ntt_pkg::SEL_ENTRY;
					ctl.ptr_inc = 1'b1;
					state_d     = sts.rpt_last ? S_IDLE : S_RPT;
				end
			end
			S_EMPTY: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					ctl.sel  = ntt_pkg::SEL_EMPTY;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/ntt_dpath.sv @@
module ntt_dpath #(
	parameter int TABLE_ENTRIES = ntt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ntt_pkg::ctl_t                        ctl,
	output ntt_pkg::sts_t                        sts,
	input  logic                                 cfg_wr_en,
	input  logic [ntt_pkg::WORD_W-1:0]           cfg_wr_data,
	input  logic [ntt_pkg::MAC_W-1:0]            station_mac,
	input  logic [ntt_pkg::WORD_W-1:0]           msg_sequence,
	input  logic signed [ntt_pkg::RSSI_W-1:0]    signal_rssi,
	input  logic                                 rssi_valid,
	input  logic [ntt_pkg::WORD_W-1:0]           time_now,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ntt_pkg::STATUS_W-1:0]         status,
	output logic [ntt_pkg::SLOT_W-1:0]           slot,
	output logic [ntt_pkg::MAC_W-1:0]            entry_mac,
	output logic [ntt_pkg::WORD_W-1:0]           seen_time,
	output logic [ntt_pkg::WORD_W-1:0]           age,
	output logic [ntt_pkg::WORD_W-1:0]           entry_sequence,
	output logic signed [ntt_pkg::RSSI_W-1:0]    entry_rssi,
	output logic                                 entry_rssi_valid,
	output logic [ntt_pkg::WORD_W-1:0]           hello_total,
	output logic                                 is_stale,
	output logic [ntt_pkg::COUNT_W-1:0]          occupied_count,
	output logic                                 last
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);
	localparam int CMP_W = (OCC_W > ntt_pkg::RES_W) ? OCC_W : ntt_pkg::RES_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	ntt_pkg::entry_t entry_mem_q [TABLE_ENTRIES];
	ntt_pkg::entry_t rdata_q;
	ntt_pkg::entry_t wdata;

	logic [TABLE_ENTRIES-1:0]     used_q;
	logic [OCC_W-1:0]             occ_q;
	logic [ntt_pkg::WORD_W-1:0]   stale_q;

	logic [ntt_pkg::MAC_W-1:0]    mac_q;
	logic [ntt_pkg::WORD_W-1:0]   seq_q;
	logic [ntt_pkg::RSSI_W-1:0]   rssi_q;
	logic                         rssi_ok_q;
	logic [ntt_pkg::WORD_W-1:0]   now_q;

	logic [IDX_W-1:0]             ptr_q;
	logic                         cmp_s1;
	logic [IDX_W-1:0]             idx_s1;

	logic                         hit_q;
	logic                         free_q;
	logic [IDX_W-1:0]             hit_idx_q;
	logic [IDX_W-1:0]             free_idx_q;
	logic [ntt_pkg::WORD_W-1:0]   hit_hellos_q;

	logic [IDX_W-1:0]             res_idx_q;
	logic                         res_new_q;
	logic [ntt_pkg::WORD_W-1:0]   res_hellos_q;
	logic [ntt_pkg::RES_W-1:0]    emitted_q;
	logic                         out_valid_q;

	logic [IDX_W-1:0]             tgt;
	logic [ntt_pkg::WORD_W-1:0]   hellos_new;
	logic [ntt_pkg::WORD_W-1:0]   age_w;
	logic [CMP_W-1:0]             occ_x;
	logic [CMP_W-1:0]             max_x;
	logic [CMP_W-1:0]             total_x;
	logic [CMP_W-1:0]             next_x;

	assign tgt        = hit_q ? hit_idx_q : free_idx_q;
	assign hellos_new = hit_q ? hit_hellos_q + 32'd1 : 32'd1;
	assign age_w      = now_q - rdata_q.seen;

	assign occ_x   = CMP_W'(occ_q);
	assign max_x   = CMP_W'(ntt_pkg::MAX_RESULTS);
	assign total_x = (occ_x < max_x) ? occ_x : max_x;
	assign next_x  = CMP_W'(emitted_q) + CMP_W'(1);

	assign wdata.mac     = mac_q;
	assign wdata.seq     = seq_q;
	assign wdata.seen    = now_q;
	assign wdata.rssi    = rssi_q;
	assign wdata.rssi_ok = rssi_ok_q;
	assign wdata.hellos  = hellos_new;

	assign sts.ptr_last = (ptr_q == LAST_IDX);
	assign sts.ptr_used = used_q[ptr_q];
	assign sts.found    = hit_q | free_q;
	assign sts.occ_zero = (occ_q == '0);
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.rpt_last = (next_x == total_x);

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q <= ntt_pkg::STALE_RESET;
		end else if (cfg_wr_en) begin
			stale_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			mac_q     <= station_mac;
			seq_q     <= msg_sequence;
			rssi_q    <= signal_rssi;
			rssi_ok_q <= rssi_valid;
			now_q     <= time_now;
		end
	end

	// table storage, one registered read port at the scan pointer
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			entry_mem_q[tgt] <= wdata;
		end
		rdata_q <= entry_mem_q[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			occ_q  <= '0;
		end else if (ctl.commit) begin
			used_q[tgt] <= 1'b1;
			if (!hit_q) begin
				occ_q <= occ_q + OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			cmp_s1    <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			emitted_q <= '0;
		end else begin
			cmp_s1 <= ctl.scan_en;
			if (ctl.cap) begin
				ptr_q     <= '0;
				hit_q     <= 1'b0;
				free_q    <= 1'b0;
				emitted_q <= '0;
			end else begin
				if (ctl.ptr_inc) begin
					ptr_q <= ptr_q + IDX_W'(1);
				end
				if (cmp_s1) begin
					if (used_q[idx_s1] && (rdata_q.mac == mac_q)) begin
						hit_q <= 1'b1;
					end
					if (!used_q[idx_s1] && !free_q) begin
						free_q <= 1'b1;
					end
				end
				if (ctl.emit && (ctl.sel == ntt_pkg::SEL_ENTRY)) begin
					emitted_q <= emitted_q + ntt_pkg::RES_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q;
		if (cmp_s1) begin
			if (used_q[idx_s1] && (rdata_q.mac == mac_q)) begin
				hit_idx_q    <= idx_s1;
				hit_hellos_q <= rdata_q.hellos;
			end
			if (!used_q[idx_s1] && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (ctl.commit) begin
			res_idx_q    <= tgt;
			res_new_q    <= !hit_q;
			res_hellos_q <= hellos_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			occupied_count <= ntt_pkg::COUNT_W'(occ_q);
			case (ctl.sel)
				ntt_pkg::SEL_OBS: begin
					status           <= res_new_q ? ntt_pkg::ST_NEW : ntt_pkg::ST_UPDATED;
					slot             <= ntt_pkg::SLOT_W'(res_idx_q);
					entry_mac        <= mac_q;
					seen_time        <= now_q;
					age              <= '0;
					entry_sequence   <= seq_q;
					entry_rssi       <= rssi_q;
					entry_rssi_valid <= rssi_ok_q;
					hello_total      <= res_hellos_q;
					is_stale         <= 1'b0;
					last             <= 1'b1;
				end
				ntt_pkg::SEL_ENTRY: begin
					status           <= ntt_pkg::ST_REPORT;
					slot             <= ntt_pkg::SLOT_W'(ptr_q);
					entry_mac        <= rdata_q.mac;
					seen_time        <= rdata_q.seen;
					age              <= age_w;
					entry_sequence   <= rdata_q.seq;
					entry_rssi       <= rdata_q.rssi;
					entry_rssi_valid <= rdata_q.rssi_ok;
					hello_total      <= rdata_q.hellos;
					is_stale         <= (age_w > stale_q);
					last             <= sts.rpt_last;
				end
				default: begin
					status           <= (ctl.sel == ntt_pkg::SEL_FULL) ?
						ntt_pkg::ST_FULL : ntt_pkg::ST_EMPTY;
					slot             <= '0;
					entry_mac        <= '0;
					seen_time        <= '0;
					age              <= '0;
					entry_sequence   <= '0;
					entry_rssi       <= '0;
					entry_rssi_valid <= 1'b0;
					hello_total      <= '0;
					is_stale         <= 1'b0;
					last             <= 1'b1;
				end
			endcase
		end
	end

endmodule

@@ rtl/neighbor_table_tracker.sv @@
// Observe item: full table scan, one entry per cycle through the registered table read port,
// then write-back (when a hit or a free slot was found) and output load.
// Report item: free entries are skipped and occupied entries are emitted, up to 16 results.
// One item is in work at a time; a new item is taken the cycle after its last result is loaded.
// arst_n clears the occupancy bits, count and control and sets the stale threshold to 30000;
// entry contents are not cleared.
module neighbor_table_tracker #(
	parameter int TABLE_ENTRIES = ntt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [ntt_pkg::WORD_W-1:0]           cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 opcode,
	input  logic [ntt_pkg::MAC_W-1:0]            station_mac,
	input  logic [ntt_pkg::WORD_W-1:0]           msg_sequence,
	input  logic signed [ntt_pkg::RSSI_W-1:0]    signal_rssi,
	input  logic                                 rssi_valid,
	input  logic [ntt_pkg::WORD_W-1:0]           time_now,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ntt_pkg::STATUS_W-1:0]         status,
	output logic [ntt_pkg::SLOT_W-1:0]           slot,
	output logic [ntt_pkg::MAC_W-1:0]            entry_mac,
	output logic [ntt_pkg::WORD_W-1:0]           seen_time,
	output logic [ntt_pkg::WORD_W-1:0]           age,
	output logic [ntt_pkg::WORD_W-1:0]           entry_sequence,
	output logic signed [ntt_pkg::RSSI_W-1:0]    entry_rssi,
	output logic                                 entry_rssi_valid,
	output logic [ntt_pkg::WORD_W-1:0]           hello_total,
	output logic                                 is_stale,
	output logic [ntt_pkg::COUNT_W-1:0]          occupied_count,
	output logic                                 last
);

	ntt_pkg::ctl_t ctl;
	ntt_pkg::sts_t sts;

	ntt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	ntt_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.sts              (sts),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.station_mac      (station_mac),
		.msg_sequence     (msg_sequence),
		.signal_rssi      (signal_rssi),
		.rssi_valid       (rssi_valid),
		.time_now         (time_now),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.slot             (slot),
		.entry_mac        (entry_mac),
		.seen_time        (seen_time),
		.age              (age),
		.entry_sequence   (entry_sequence),
		.entry_rssi       (entry_rssi),
		.entry_rssi_valid (entry_rssi_valid),
		.hello_total      (hello_total),
		.is_stale         (is_stale),
		.occupied_count   (occupied_count),
		.last             (last)
	);

endmodule
